>>> rtl/s88cd_pkg.sv
package s88cd_pkg;

  // One S88 module carries eight sensor bits; one image row holds one module.
  localparam int BITS_PER_MODULE = 8;
  localparam int BPM_W = 3;

  localparam int CMD_W = 2;
  localparam int KIND_W = 2;
  localparam int ID_W = 10;
  localparam int MC_W = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SHIFT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FORGET = 2'd2;

  localparam logic [KIND_W-1:0] EV_CHANGE = 2'd0;
  localparam logic [KIND_W-1:0] EV_SCAN   = 2'd1;
  localparam logic [KIND_W-1:0] EV_ACK    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT  = 1'b1;

  localparam logic [MC_W-1:0] MC_RESET = 7'd2;

  // Result record queue.
  localparam int RF_DEPTH = 4;
  localparam int RF_AW = $clog2(RF_DEPTH);
  localparam int RF_CW = $clog2(RF_DEPTH + 1);

  typedef logic [BITS_PER_MODULE-1:0] row_t;

  typedef struct packed {
    logic empty;
    logic room;
  } img_stat_t;

  // Every result that one input item causes, in delivery order:
  // acknowledge, left change, right change, scan summary.
  typedef struct packed {
    logic            ack;
    logic            lev;
    logic [ID_W-1:0] lid;
    logic            lact;
    logic            rev;
    logic [ID_W-1:0] rid;
    logic            ract;
    logic            sum;
    logic            chg;
  } rec_t;

endpackage

>>> rtl/dual_s88_scan_change_detect.sv
// Dual S88 feedback scanner with change detection.
//
// Input channel (in_valid/in_ready): one transfer carries a command (start,
// shift, forget), the two sampled chain bits and the program-enable level.
// Output channel (out_valid/out_ready): one transfer carries one result:
// a command acknowledge, a sensor change, or the scan summary. The final
// result caused by an input item has last set.
// Configuration (cfg_wr_en/cfg_index/cfg_data) writes the module count or
// the report mode, as cfg_index selects; a new module count is used at the
// next start. Results of an item are queued at its transfer and offered in
// order. One item can be taken every cycle while in_ready is high. The
// sensor image is a RAM of one 8-bit row per module with a single write
// port; a pair of finished rows drains through a small write-back buffer,
// and a start that finds that buffer busy, or that abandons a partly
// scanned module, holds in_ready low while the rows are written and the
// first pair is fetched again. A receiver stall fills the result queue
// (four items), after which in_ready drops until results are taken. Reset
// clears all control state and marks every image row unwritten, so the
// image reads as all clear without any clearing pass; the block is ready
// as soon as reset ends.
module dual_s88_scan_change_detect #(
  parameter int MAX_MODULES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [s88cd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [s88cd_pkg::MC_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [s88cd_pkg::CMD_W-1:0]      cmd,
  input  logic                             bit_left,
  input  logic                             bit_right,
  input  logic                             report_allowed,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [s88cd_pkg::KIND_W-1:0]     event_kind,
  output logic [s88cd_pkg::ID_W-1:0]       sensor_id,
  output logic                             sensor_active,
  output logic                             scan_changed,
  output logic                             last
);

  import s88cd_pkg::*;

  localparam int HALF_MAX = (MAX_MODULES / 2) * BITS_PER_MODULE;
  // Shift counter within one chain, modules per chain, image row address.
  localparam int SW = $clog2(HALF_MAX);
  localparam int HW = $clog2(MAX_MODULES / 2 + 1);
  localparam int AW = $clog2(MAX_MODULES);
  localparam int CW = HW + BPM_W;

  // Configuration registers.
  logic [MC_W-1:0] module_count;
  logic            report_mode;

  // Scan state.
  logic            image_valid;
  logic            scan_active;
  logic            any_change;
  logic            skipped;
  logic [SW-1:0]   shift_count;
  logic [HW-1:0]   h8;
  logic            fetch_pending;
  row_t            work_l;
  row_t            work_r;

  logic            acc;
  logic            is_start;
  logic            is_shift;
  logic            is_forget;
  logic            shift_go;
  logic            abort;
  logic            start_read_now;
  logic            fetch_issue;

  logic [MC_W-1:0]    mc_clamp;
  logic [HW-1:0]      h8_new;
  logic [CW-1:0]      half;
  logic [BPM_W-1:0]   bpos;
  logic               first;
  logic               grp_end;
  logic               last_shift;
  logic [AW-1:0]      grp;

  row_t  cur_l;
  row_t  cur_r;
  row_t  new_l;
  row_t  new_r;
  logic  diff_l;
  logic  diff_r;
  logic  upd_l;
  logic  upd_r;
  logic  any_next;
  logic  skip_next;

  // Image interface.
  logic             img_rd_en;
  logic [AW-1:0]    img_rd_row_l;
  logic [AW-1:0]    img_rd_row_r;
  row_t             img_rd_l;
  row_t             img_rd_r;
  logic             img_wb_en;
  row_t             img_wb_l;
  row_t             img_wb_r;
  img_stat_t        img_stat;

  // Result queue interface.
  rec_t             rec;
  logic             rf_push;
  logic             rf_full;

  assign in_ready = !fetch_pending && img_stat.room && !rf_full;
  assign acc      = in_valid && in_ready;

  assign is_start  = (cmd == CMD_START);
  assign is_shift  = (cmd == CMD_SHIFT);
  assign is_forget = (cmd == CMD_FORGET);

  // Module count is clamped and rounded down to even; h8 is modules per chain.
  assign mc_clamp = (module_count > MC_W'(MAX_MODULES)) ? MC_W'(MAX_MODULES) : module_count;
  assign h8_new   = HW'(mc_clamp >> 1);
  assign half     = {h8, {BPM_W{1'b0}}};

  assign bpos       = shift_count[BPM_W-1:0];
  assign first      = (bpos == '0);
  assign grp_end    = &bpos;
  assign grp        = AW'(shift_count >> BPM_W);
  assign last_shift = ((CW'(shift_count) + CW'(1)) == half);

  assign shift_go = acc && is_shift && scan_active;

  // Leaving a module half done: its working rows still hold the only copy
  // of the bits already updated, so they go back to the image.
  assign abort = acc && (is_start || is_forget) && scan_active && !first;

  assign start_read_now = acc && is_start && !abort && img_stat.empty;
  assign fetch_issue    = fetch_pending && img_stat.empty;

  // The first bit of a module takes its row fresh from the image; later bits
  // work on the row held in the working register.
  always_comb begin
    cur_l = first ? img_rd_l : work_l;
    cur_r = first ? img_rd_r : work_r;

    diff_l = !image_valid || (cur_l[bpos] != bit_left);
    diff_r = !image_valid || (cur_r[bpos] != bit_right);
    upd_l  = diff_l && report_allowed;
    upd_r  = diff_r && report_allowed;

    new_l = cur_l;
    new_r = cur_r;
    if (upd_l) begin
      new_l[bpos] = bit_left;
    end
    if (upd_r) begin
      new_r[bpos] = bit_right;
    end

    any_next  = any_change || diff_l || diff_r;
    skip_next = skipped || ((diff_l || diff_r) && !report_allowed);
  end

  // Row reads: the pair for a new scan, or the next module's pair fetched
  // on the last bit of the current module.
  always_comb begin
    img_rd_en = fetch_issue || start_read_now || (shift_go && grp_end);
    if (fetch_issue) begin
      img_rd_row_l = '0;
      img_rd_row_r = AW'(h8);
    end else if (acc && is_start) begin
      img_rd_row_l = '0;
      img_rd_row_r = AW'(h8_new);
    end else begin
      img_rd_row_l = grp + AW'(1);
      img_rd_row_r = AW'(h8) + grp + AW'(1);
    end
  end

  assign img_wb_en = (shift_go && grp_end) || abort;
  assign img_wb_l  = shift_go ? new_l : work_l;
  assign img_wb_r  = shift_go ? new_r : work_r;

  always_comb begin
    rec      = '0;
    rec.ack  = is_start || is_forget;
    rec.lev  = shift_go && upd_l && report_mode;
    rec.lid  = ID_W'(shift_count) + ID_W'(1);
    rec.lact = bit_left;
    rec.rev  = shift_go && upd_r && report_mode;
    rec.rid  = ID_W'(half) + ID_W'(shift_count) + ID_W'(1);
    rec.ract = bit_right;
    rec.sum  = shift_go && last_shift;
    rec.chg  = any_next;
  end

  assign rf_push = acc && (rec.ack || rec.lev || rec.rev || rec.sum);

  always_ff @(posedge clk) begin
    if (shift_go) begin
      work_l <= new_l;
      work_r <= new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      module_count  <= MC_RESET;
      report_mode   <= 1'b0;
      image_valid   <= 1'b0;
      scan_active   <= 1'b0;
      any_change    <= 1'b0;
      skipped       <= 1'b0;
      shift_count   <= '0;
      h8            <= '0;
      fetch_pending <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MODULES: module_count <= cfg_data;
          CFG_REPORT:  report_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (fetch_issue) begin
        fetch_pending <= 1'b0;
      end
      if (acc) begin
        case (cmd)
          CMD_START: begin
            h8            <= h8_new;
            shift_count   <= '0;
            any_change    <= 1'b0;
            skipped       <= 1'b0;
            scan_active   <= (h8_new != '0);
            fetch_pending <= !start_read_now;
          end
          CMD_FORGET: begin
            image_valid <= 1'b0;
            scan_active <= 1'b0;
            shift_count <= '0;
          end
          CMD_SHIFT: begin
            if (scan_active) begin
              any_change <= any_next;
              skipped    <= skip_next;
              if (last_shift) begin
                if (!skip_next) begin
                  image_valid <= 1'b1;
                end
                scan_active <= 1'b0;
                shift_count <= '0;
              end else begin
                shift_count <= shift_count + SW'(1);
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  s88cd_image #(
    .ROW_AW(AW)
  ) u_image (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (img_rd_en),
    .rd_row_l  (img_rd_row_l),
    .rd_row_r  (img_rd_row_r),
    .rd_data_l (img_rd_l),
    .rd_data_r (img_rd_r),
    .wb_en     (img_wb_en),
    .wb_row_l  (grp),
    .wb_data_l (img_wb_l),
    .wb_row_r  (AW'(h8) + grp),
    .wb_data_r (img_wb_r),
    .stat      (img_stat)
  );

  s88cd_rfifo u_rfifo (
    .clk           (clk),
    .rst           (rst),
    .push          (rf_push),
    .rec           (rec),
    .full          (rf_full),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .sensor_id     (sensor_id),
    .sensor_active (sensor_active),
    .scan_changed  (scan_changed),
    .last          (last)
  );

  // Every start or forget transfer is answered, so a result is waiting next cycle.
  a_cmd_answered: assert property (@(posedge clk) disable iff (rst)
    acc && (is_start || is_forget) |=> out_valid)
    else $error("command transfer left no result");

  // A running scan never counts past the chain length latched at start.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    scan_active |-> (CW'(shift_count) < half))
    else $error("shift count beyond chain length");

  // Chains are whole modules long, so the final shift always closes a row.
  a_end_on_row: assert property (@(posedge clk) disable iff (rst)
    shift_go && last_shift |-> grp_end && img_wb_en)
    else $error("scan ended inside a module row");

endmodule

>>> rtl/s88cd_ram.sv
module s88cd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                     rdata_a,
  output logic [WIDTH-1:0]                     rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> rtl/s88cd_image.sv
module s88cd_image #(
  parameter int ROW_AW = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [ROW_AW-1:0]       rd_row_l,
  input  logic [ROW_AW-1:0]       rd_row_r,
  output s88cd_pkg::row_t         rd_data_l,
  output s88cd_pkg::row_t         rd_data_r,
  input  logic                    wb_en,
  input  logic [ROW_AW-1:0]       wb_row_l,
  input  s88cd_pkg::row_t         wb_data_l,
  input  logic [ROW_AW-1:0]       wb_row_r,
  input  s88cd_pkg::row_t         wb_data_r,
  output s88cd_pkg::img_stat_t    stat
);

  import s88cd_pkg::*;

  localparam int ROWS = 1 << ROW_AW;
  localparam int WB_DEPTH = 4;
  localparam int WB_AW = $clog2(WB_DEPTH);
  localparam int WB_CW = $clog2(WB_DEPTH + 1);

  typedef struct packed {
    logic [ROW_AW-1:0] row;
    row_t              data;
  } wb_ent_t;

  wb_ent_t          wb_q [WB_DEPTH];
  logic [WB_AW-1:0] wb_wp;
  logic [WB_AW-1:0] wb_rp;
  logic [WB_CW-1:0] wb_cnt;
  logic [WB_CW-1:0] wb_cnt_next;
  logic             wb_pop;
  wb_ent_t          wb_head;

  logic [ROWS-1:0]  row_ok;
  logic             ok_l;
  logic             ok_r;
  row_t             ram_l;
  row_t             ram_r;

  // A finished row pair arrives at once; the RAM takes one row per cycle.
  assign wb_head = wb_q[wb_rp];
  assign wb_pop = (wb_cnt != '0);

  always_comb begin
    wb_cnt_next = wb_cnt;
    if (wb_en) begin
      wb_cnt_next = wb_cnt_next + WB_CW'(2);
    end
    if (wb_pop) begin
      wb_cnt_next = wb_cnt_next - WB_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      wb_q[wb_wp]             <= '{row: wb_row_l, data: wb_data_l};
      wb_q[wb_wp + WB_AW'(1)] <= '{row: wb_row_r, data: wb_data_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_wp  <= '0;
      wb_rp  <= '0;
      wb_cnt <= '0;
      row_ok <= '0;
    end else begin
      if (wb_en) begin
        wb_wp <= wb_wp + WB_AW'(2);
      end
      if (wb_pop) begin
        wb_rp <= wb_rp + WB_AW'(1);
        row_ok[wb_head.row] <= 1'b1;
      end
      wb_cnt <= wb_cnt_next;
    end
  end

  // A row that was never written reads as all clear.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ok_l <= row_ok[rd_row_l];
      ok_r <= row_ok[rd_row_r];
    end
  end

  s88cd_ram #(
    .WIDTH(BITS_PER_MODULE),
    .DEPTH(ROWS)
  ) u_ram (
    .clk     (clk),
    .we      (wb_pop),
    .waddr   (wb_head.row),
    .wdata   (wb_head.data),
    .re      (rd_en),
    .raddr_a (rd_row_l),
    .raddr_b (rd_row_r),
    .rdata_a (ram_l),
    .rdata_b (ram_r)
  );

  assign rd_data_l = ok_l ? ram_l : '0;
  assign rd_data_r = ok_r ? ram_r : '0;

  assign stat.empty = (wb_cnt == '0);
  assign stat.room  = (wb_cnt <= WB_CW'(WB_DEPTH - 2));

endmodule

>>> rtl/s88cd_rfifo.sv
module s88cd_rfifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  s88cd_pkg::rec_t               rec,
  output logic                          full,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [s88cd_pkg::KIND_W-1:0]  event_kind,
  output logic [s88cd_pkg::ID_W-1:0]    sensor_id,
  output logic                          sensor_active,
  output logic                          scan_changed,
  output logic                          last
);

  import s88cd_pkg::*;

  localparam int SUB_N = 4;

  rec_t             q [RF_DEPTH];
  logic [RF_AW-1:0] wp;
  logic [RF_AW-1:0] rp;
  logic [RF_CW-1:0] cnt;
  logic [SUB_N-1:0] done;
  rec_t             head;
  logic [SUB_N-1:0] pres;
  logic [SUB_N-1:0] rem;
  logic [SUB_N-1:0] sel;
  logic             xfer;
  logic             pop;

  assign head = q[rp];
  assign pres = {head.sum, head.rev, head.lev, head.ack};
  assign rem  = pres & ~done;
  // Lowest outstanding result of the head record goes out first.
  assign sel  = rem & (~rem + SUB_N'(1));
  assign last = ((rem & ~sel) == '0);

  assign out_valid = (cnt != '0);
  assign full      = (cnt == RF_CW'(RF_DEPTH));
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && last;

  always_comb begin
    event_kind    = EV_ACK;
    sensor_id     = '0;
    sensor_active = 1'b0;
    scan_changed  = 1'b0;
    if (sel[1]) begin
      event_kind    = EV_CHANGE;
      sensor_id     = head.lid;
      sensor_active = head.lact;
    end else if (sel[2]) begin
      event_kind    = EV_CHANGE;
      sensor_id     = head.rid;
      sensor_active = head.ract;
    end else if (sel[3]) begin
      event_kind   = EV_SCAN;
      scan_changed = head.chg;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      cnt  <= '0;
      done <= '0;
    end else begin
      if (push) begin
        wp <= wp + RF_AW'(1);
      end
      if (pop) begin
        rp   <= rp + RF_AW'(1);
        done <= '0;
      end else if (xfer) begin
        done <= done | sel;
      end
      cnt <= cnt + RF_CW'(push) - RF_CW'(pop);
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the dual S88 scanner.
//
// Every input transfer is fed to a predictor that keeps its own copy of the
// 512-bit sensor image, the scan position and the two registers. The
// predictor queues the results that the transfer must cause. A checker
// compares each output transfer, field by field, with the oldest queued
// result. The sender works in bursts with random gaps, and the receiver
// stalls on a pattern that changes from phase to phase.
module testbench;
  import s88cd_pkg::*;

  // Command code 3 has no meaning; the block must ignore it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int IMAGE_BITS    = 512;
  localparam int CAP_MODULES   = 64;
  // The head of the block tells of a hold-off of in_ready after a start; the
  // bench waits SETTLE_CYCLES beyond the drain before any register write and
  // at the end to cover it.
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RUN_LIMIT     = 1000000;
  localparam int RANDOM_ITEMS  = 70;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic              active;
    logic              changed;
    logic              last;
  } sensor_result_t;

  // Block ports. All inputs start at known values.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MODULES;
  logic [MC_W-1:0]      cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd = CMD_START;
  logic                 bit_left = 1'b0;
  logic                 bit_right = 1'b0;
  logic                 report_allowed = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    event_kind;
  logic [ID_W-1:0]      sensor_id;
  logic                 sensor_active;
  logic                 scan_changed;
  logic                 last;

  // Predicted state of the scanner.
  logic [IMAGE_BITS-1:0] img_bits;
  logic                  img_valid;
  int unsigned           shift_pos;
  int unsigned           chain_len;
  logic                  scanning;
  logic                  scan_dirty;
  logic                  lost_update;
  logic [MC_W-1:0]       mod_count;
  logic                  events_on;

  // Results still owed by the block, oldest first, and the results of the
  // item being predicted.
  sensor_result_t pending_results[$];
  sensor_result_t item_results[$];
  sensor_result_t want;

  int          fail_count = 0;
  int unsigned burst_left = 0;
  logic        steady_sender = 1'b0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned flip_rate = 0;
  int unsigned idle_cycles;
  int unsigned run_cycles;

  dual_s88_scan_change_detect u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .bit_left       (bit_left),
    .bit_right      (bit_right),
    .report_allowed (report_allowed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .sensor_id      (sensor_id),
    .sensor_active  (sensor_active),
    .scan_changed   (scan_changed),
    .last           (last)
  );

  always #5 clk = ~clk;

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Compare one chain bit with the image. A bit is a change when it differs
  // from the stored bit or when the image is not valid. A change is stored
  // only while reporting is allowed; otherwise the scan cannot validate the
  // image.
  task automatic predict_sensor(input int unsigned index, input logic value,
                                input logic allowed);
    int unsigned    slot;
    sensor_result_t ev;
    slot = index % IMAGE_BITS;
    if (!img_valid || img_bits[slot] != value) begin
      scan_dirty = 1'b1;
      if (!allowed) begin
        lost_update = 1'b1;
      end else begin
        img_bits[slot] = value;
        if (events_on) begin
          ev = '0;
          ev.kind = EV_CHANGE;
          ev.id = ID_W'(slot + 1);
          ev.active = value;
          item_results.push_back(ev);
        end
      end
    end
  endtask

  // Work out the results of one accepted item and queue them. took_effect is
  // low for items that the block ignores.
  task automatic predict_item(input logic [CMD_W-1:0] c, input logic bl,
                              input logic br, input logic ra,
                              output logic took_effect);
    sensor_result_t ack;
    sensor_result_t summary;
    sensor_result_t tail;
    int unsigned    mc;
    took_effect = 1'b1;
    ack = '0;
    ack.kind = EV_ACK;
    item_results.delete();
    case (c)
      CMD_START: begin
        // The module count is clamped and rounded down to an even value;
        // a chain of zero bits starts no scan, but the start is still
        // acknowledged. A running scan is restarted.
        mc = (mod_count > CAP_MODULES) ? CAP_MODULES : mod_count;
        chain_len = (mc / 2) * BITS_PER_MODULE;
        shift_pos = 0;
        scan_dirty = 1'b0;
        lost_update = 1'b0;
        scanning = (chain_len != 0);
        item_results.push_back(ack);
      end
      CMD_FORGET: begin
        img_valid = 1'b0;
        scanning = 1'b0;
        shift_pos = 0;
        item_results.push_back(ack);
      end
      CMD_SHIFT: begin
        if (!scanning) begin
          took_effect = 1'b0;
        end else begin
          // Left chain first, then right chain, then the summary.
          predict_sensor(shift_pos, bl, ra);
          predict_sensor(chain_len + shift_pos, br, ra);
          shift_pos++;
          if (shift_pos >= chain_len) begin
            summary = '0;
            summary.kind = EV_SCAN;
            summary.changed = scan_dirty;
            item_results.push_back(summary);
            if (!lost_update) img_valid = 1'b1;
            scanning = 1'b0;
            shift_pos = 0;
          end
        end
      end
      default: begin
        took_effect = 1'b0;
      end
    endcase
    if (item_results.size() > 0) begin
      tail = item_results.pop_back();
      tail.last = 1'b1;
      item_results.push_back(tail);
      foreach (item_results[i]) pending_results.push_back(item_results[i]);
    end
  endtask

  // Offer one item and hold it until the transfer. Called at a rising edge.
  // valid stays high after the transfer so that the next item of a burst
  // follows without a gap.
  task automatic send_item(input logic [CMD_W-1:0] c, input logic bl,
                           input logic br, input logic ra,
                           output logic took_effect);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (steady_sender) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(9, 30);
      else gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= c;
    bit_left <= bl;
    bit_right <= br;
    report_allowed <= ra;
    do @(posedge clk); while (!in_ready);
    predict_item(c, bl, br, ra, took_effect);
  endtask

  // Stop sending and wait until every owed result has arrived, then let
  // the block settle. Called at a rising edge right after a transfer.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers are written only when the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [MC_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MODULES) mod_count = data;
    else events_on = data[0];
  endtask

  // Chain bit that follows the stored image, flipped now and then.
  function automatic logic chain_bit(input int unsigned slot);
    return img_bits[slot % IMAGE_BITS] ^ ($urandom_range(0, 99) < flip_rate);
  endfunction

  // Mostly short chains; a few reach or pass the clamp.
  function automatic logic [MC_W-1:0] pick_modules();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return MC_W'($urandom_range(0, 1));
    if (r < 75) return MC_W'($urandom_range(2, 8));
    if (r < 96) return MC_W'($urandom_range(9, 24));
    return MC_W'($urandom_range(64, 127));
  endfunction

  // Reset values: two modules, summary only, image invalid. An unknown
  // command and a shift with no scan running are ignored. The first scan
  // must report a change since the image is not yet valid.
  task automatic test_idle_and_defaults();
    logic took;
    send_item(CMD_UNUSED, 1'b1, 1'b1, 1'b1, took);
    send_item(CMD_SHIFT, 1'b1, 1'b0, 1'b1, took);
    send_item(CMD_START, 1'b0, 1'b0, 1'b0, took);
    for (int i = 0; i < 8; i++) begin
      send_item(CMD_SHIFT, i[0], ~i[0], 1'b1, took);
    end
  endtask

  // Per-sensor events, blocked updates, restart, forget and chains that
  // give no scan at all.
  task automatic test_change_reporting();
    logic took;
    wait_for_drain();
    write_reg(CFG_REPORT, 7'h7F);
    // An odd count rounds down: three modules scan like two.
    write_reg(CFG_MODULES, 7'd3);
    flip_rate = 0;
    send_item(CMD_START, 1'b0, 1'b0, 1'b1, took);
    // Bits that match the now valid image give no event.
    send_item(CMD_SHIFT, chain_bit(0), chain_bit(8), 1'b1, took);
    // Both bits flipped: a left and a right event on one item.
    send_item(CMD_SHIFT, ~chain_bit(1), ~chain_bit(9), 1'b1, took);
    // A change while reporting is blocked is neither stored nor reported.
    send_item(CMD_SHIFT, ~chain_bit(2), chain_bit(10), 1'b0, took);
    // Start while a scan runs restarts it; forget aborts it and drops the
    // image, after which a shift is ignored.
    send_item(CMD_START, 1'b1, 1'b1, 1'b1, took);
    send_item(CMD_FORGET, 1'b0, 1'b1, 1'b1, took);
    send_item(CMD_SHIFT, 1'b1, 1'b1, 1'b1, took);
    // A full scan with one blocked change must leave the image invalid, so
    // the next scan reports every bit again.
    send_item(CMD_START, 1'b0, 1'b0, 1'b0, took);
    for (int i = 0; i < 8; i++) begin
      send_item(CMD_SHIFT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), i != 2,
                took);
    end
    send_item(CMD_START, 1'b0, 1'b0, 1'b0, took);
    send_item(CMD_SHIFT, 1'b1, 1'b0, 1'b1, took);
    // Zero and one module leave no bits per chain: acknowledge only.
    wait_for_drain();
    write_reg(CFG_MODULES, 7'd0);
    send_item(CMD_START, 1'b0, 1'b0, 1'b1, took);
    send_item(CMD_SHIFT, 1'b1, 1'b1, 1'b1, took);
    wait_for_drain();
    write_reg(CFG_MODULES, 7'd1);
    send_item(CMD_START, 1'b1, 1'b1, 1'b1, took);
  endtask

  // The largest chain: a count above the limit is clamped to 64 modules,
  // so the right chain reaches sensor 512. With the image forgotten every
  // sensor gives an event, which walks every bit of the sensor id.
  task automatic test_full_chain();
    logic took;
    wait_for_drain();
    write_reg(CFG_MODULES, 7'h7F);
    write_reg(CFG_REPORT, 7'd1);
    stall_mode = 2;
    send_item(CMD_FORGET, 1'b0, 1'b0, 1'b0, took);
    send_item(CMD_START, 1'b0, 1'b0, 1'b0, took);
    for (int i = 0; i < 256; i++) begin
      send_item(CMD_SHIFT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                took);
    end
  endtask

  // Phases of mostly well-formed scans with random content, with restarts,
  // forgets, stray shifts and unknown commands mixed in. Each phase starts
  // from an idle block with new register values, possibly in mid-scan, and
  // with a new receiver pattern and sender behavior.
  task automatic test_random_traffic();
    int unsigned      counted;
    int unsigned      phase_items;
    int unsigned      pick;
    logic             took;
    logic             bl;
    logic             br;
    logic             ra;
    logic [CMD_W-1:0] c;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      wait_for_drain();
      case ($urandom_range(0, 3))
        0: write_reg(CFG_MODULES, pick_modules());
        1: write_reg(CFG_REPORT, MC_W'($urandom));
        default: begin
          write_reg(CFG_MODULES, pick_modules());
          write_reg(CFG_REPORT, MC_W'($urandom));
        end
      endcase
      stall_mode = $urandom_range(0, 2);
      steady_sender = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: flip_rate = 0;
        1: flip_rate = 3;
        default: flip_rate = 15;
      endcase
      phase_items = $urandom_range(15, 60);
      while (phase_items > 0 && counted < RANDOM_ITEMS) begin
        pick = $urandom_range(0, 99);
        bl = 1'($urandom_range(0, 1));
        br = 1'($urandom_range(0, 1));
        ra = ($urandom_range(0, 19) != 0);
        if (scanning) begin
          if (pick < 92) begin
            c = CMD_SHIFT;
            bl = chain_bit(shift_pos);
            br = chain_bit(chain_len + shift_pos);
          end else if (pick < 95) begin
            c = CMD_START;
          end else if (pick < 98) begin
            c = CMD_FORGET;
          end else begin
            c = CMD_UNUSED;
          end
        end else begin
          if (pick < 80) c = CMD_START;
          else if (pick < 90) c = CMD_SHIFT;
          else if (pick < 95) c = CMD_FORGET;
          else c = CMD_UNUSED;
        end
        send_item(c, bl, br, ra, took);
        if (took) begin
          counted++;
          phase_items--;
        end
      end
    end
  endtask

  // Output checker and receiver stall pattern. Mode 0 never stalls, mode 1
  // stalls at random on single cycles, mode 2 stalls in stretches.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          log_failure($sformatf("unexpected result kind %0d id %0d active %0b changed %0b last %0b",
                                event_kind, sensor_id, sensor_active, scan_changed, last));
        end else begin
          want = pending_results.pop_front();
          if (want.kind !== event_kind || want.id !== sensor_id ||
              want.active !== sensor_active || want.changed !== scan_changed ||
              want.last !== last) begin
            log_failure($sformatf({"expected kind %0d id %0d active %0b changed %0b last %0b,",
                                   " got kind %0d id %0d active %0b changed %0b last %0b"},
                                  want.kind, want.id, want.active, want.changed, want.last,
                                  event_kind, sensor_id, sensor_active, scan_changed, last));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stall_mode == 1) begin
        out_ready <= ($urandom_range(0, 2) != 0);
      end else if (stall_mode == 2 && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run with a failure when nothing has been transferred for too long or the run goes on too long.
  initial begin : watchdog
    idle_cycles = 0;
    run_cycles = 0;
    while (idle_cycles < IDLE_LIMIT && run_cycles < RUN_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      run_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    img_bits = '0;
    img_valid = 1'b0;
    shift_pos = 0;
    chain_len = 0;
    scanning = 1'b0;
    scan_dirty = 1'b0;
    lost_update = 1'b0;
    mod_count = MC_RESET;
    events_on = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_idle_and_defaults();
    test_change_reporting();
    test_full_chain();
    test_random_traffic();
    wait_for_drain();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/s88cd_pkg.sv
rtl/s88cd_ram.sv
rtl/s88cd_image.sv
rtl/s88cd_rfifo.sv
rtl/dual_s88_scan_change_detect.sv
tb/testbench.sv
